// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the sorter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/des_pkg.sv =====
// shared types for the descending exchange sorter
package des_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_I,
        ST_RD_J,
        ST_CMP,
        ST_WR_I,
        ST_WR_J,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_HOLD
    } t_state;

    localparam int unsigned KEY_BITS = 256;

endpackage

// ===== hw/rtl/descending_exchange_sorter_core.sv =====
// top level of the descending exchange sorter
// Loads one entry per transfer into a single-port entry ram (256-bit key,
// valid flag, tag). After the transfer marked last, an exchange sort runs
// over the stored n entries. Each outer pass reads entry i once into a
// register. Each of the n(n-1)/2 compare steps reads entry j through the
// one ram port and compares it on the cycle after. On a swap, both entries
// are written back, one after the other, through the same port. Then the
// entries leave one per result transfer: each is read, captured and held
// until taken. Loading accepts one entry per cycle. No input is taken
// during the sort and emission. Entries beyond MAX_ENTRIES are dropped and
// every result of that set shows overflowed. Tags are kept to TAG_BITS
// bits.
`include "assert_macros.svh"

module descending_exchange_sorter_core #(
    parameter int unsigned MAX_ENTRIES = 32,
    parameter int unsigned TAG_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [63:0]         i_key_word3,
    input  logic [63:0]         i_key_word2,
    input  logic [63:0]         i_key_word1,
    input  logic [63:0]         i_key_word0,
    input  logic                i_has_score,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [63:0]         o_out_key_word3,
    output logic [63:0]         o_out_key_word2,
    output logic [63:0]         o_out_key_word1,
    output logic [63:0]         o_out_key_word0,
    output logic                o_out_has_score,
    output logic [TAG_BITS-1:0] o_out_tag,
    output logic                o_out_last,
    output logic                o_overflowed
);
    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EW = des_pkg::KEY_BITS + 1 + TAG_BITS;

    // entry word layout: key, valid, tag
    des_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [AW-1:0]   r_i, n_i, r_j, n_j;
    logic [EW-1:0]   r_ei, n_ei, r_ej, n_ej;
    logic            r_fresh_i;
    logic            r_oval, n_oval;
    logic [EW-1:0]   r_oent, n_oent;
    logic            r_olast, n_olast;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [EW-1:0]   ram_wdata, ram_rdata;
    logic            in_xfer, out_xfer, full, swap;

    des_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_stall  = (r_state != des_pkg::ST_LOAD);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_oval && !i_stall;
    assign full     = (r_count == CW'(MAX_ENTRIES));
    // entry j comes straight from the ram; both valid and key i below key j
    assign swap = r_ei[TAG_BITS] && ram_rdata[TAG_BITS] &&
                  (r_ei[EW-1 -: des_pkg::KEY_BITS] < ram_rdata[EW-1 -: des_pkg::KEY_BITS]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            des_pkg::ST_LOAD: begin
                if (in_xfer && i_last) begin
                    n_state = (r_count + CW'(!full) > CW'(1)) ? des_pkg::ST_RD_I
                                                              : des_pkg::ST_OUT_RD;
                end
            end
            des_pkg::ST_RD_I:  n_state = des_pkg::ST_RD_J;
            des_pkg::ST_RD_J:  n_state = des_pkg::ST_CMP;
            des_pkg::ST_CMP: begin
                if (swap) begin
                    n_state = des_pkg::ST_WR_I;
                end else if (CW'(r_j) + CW'(1) < r_count) begin
                    n_state = des_pkg::ST_RD_J;
                end else if (CW'(r_i) + CW'(2) < r_count) begin
                    n_state = des_pkg::ST_RD_I;
                end else begin
                    n_state = des_pkg::ST_OUT_RD;
                end
            end
            des_pkg::ST_WR_I:  n_state = des_pkg::ST_WR_J;
            des_pkg::ST_WR_J: begin
                if (CW'(r_j) + CW'(1) < r_count) begin
                    n_state = des_pkg::ST_RD_J;
                end else if (CW'(r_i) + CW'(2) < r_count) begin
                    n_state = des_pkg::ST_RD_I;
                end else begin
                    n_state = des_pkg::ST_OUT_RD;
                end
            end
            des_pkg::ST_OUT_RD:  n_state = des_pkg::ST_OUT_CAP;
            des_pkg::ST_OUT_CAP: n_state = des_pkg::ST_OUT_HOLD;
            des_pkg::ST_OUT_HOLD: begin
                if (out_xfer) begin
                    n_state = r_olast ? des_pkg::ST_LOAD : des_pkg::ST_OUT_RD;
                end
            end
            default: n_state = des_pkg::ST_LOAD;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_ei      = r_ei;
        n_ej      = r_ej;
        n_oval    = r_oval;
        n_oent    = r_oent;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_addr  = r_j;
        ram_wdata = r_ei;
        case (r_state)
            des_pkg::ST_LOAD: begin
                ram_addr  = r_count[AW-1:0];
                ram_wdata = {i_key_word3, i_key_word2, i_key_word1, i_key_word0,
                             i_has_score, i_tag};
                if (in_xfer) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_i = '0;
                    n_j = AW'(1);
                end
            end
            des_pkg::ST_RD_I: begin
                ram_addr = r_i;
            end
            des_pkg::ST_RD_J: begin
                ram_addr = r_j;
            end
            des_pkg::ST_CMP: begin
                n_ej = ram_rdata;
                if (!swap) begin
                    if (CW'(r_j) + CW'(1) < r_count) begin
                        n_j = r_j + AW'(1);
                    end else begin
                        n_i = r_i + AW'(1);
                        n_j = r_i + AW'(2);
                    end
                end
            end
            des_pkg::ST_WR_I: begin
                ram_we    = 1'b1;
                ram_addr  = r_i;
                ram_wdata = r_ej;
            end
            des_pkg::ST_WR_J: begin
                ram_we    = 1'b1;
                ram_addr  = r_j;
                ram_wdata = r_ei;
                n_ei      = r_ej;
                if (CW'(r_j) + CW'(1) < r_count) begin
                    n_j = r_j + AW'(1);
                end else begin
                    n_i = r_i + AW'(1);
                    n_j = r_i + AW'(2);
                end
            end
            des_pkg::ST_OUT_RD: begin
                ram_addr = r_i;
            end
            des_pkg::ST_OUT_CAP: begin
                n_oval  = 1'b1;
                n_oent  = ram_rdata;
                n_olast = (CW'(r_i) + CW'(1) == r_count);
            end
            des_pkg::ST_OUT_HOLD: begin
                if (out_xfer) begin
                    n_oval = 1'b0;
                    n_i    = r_i + AW'(1);
                    if (r_olast) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= des_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
        end
    end

    // payload registers; entry i captured in ST_RD_J from the ram read issued in ST_RD_I
    always_ff @(posedge i_clk) begin
        r_i       <= (n_state == des_pkg::ST_OUT_RD && r_state != des_pkg::ST_OUT_HOLD) ?
                     '0 : n_i;
        r_j       <= n_j;
        r_fresh_i <= (r_state == des_pkg::ST_RD_I);
        r_ei      <= (r_state == des_pkg::ST_RD_J && r_fresh_i) ? ram_rdata : n_ei;
        r_ej      <= n_ej;
        r_oent    <= n_oent;
        r_olast   <= n_olast;
    end

    assign o_valid         = r_oval;
    assign o_out_key_word3 = r_oent[EW-1 -: 64];
    assign o_out_key_word2 = r_oent[EW-65 -: 64];
    assign o_out_key_word1 = r_oent[EW-129 -: 64];
    assign o_out_key_word0 = r_oent[EW-193 -: 64];
    assign o_out_has_score = r_oent[TAG_BITS];
    assign o_out_tag       = r_oent[TAG_BITS-1:0];
    assign o_out_last      = r_olast;
    assign o_overflowed    = r_ovf;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CW'(MAX_ENTRIES),
        "entry count beyond capacity")
    `ASSERT_ALWAYS(a_valid_only_hold, i_clk, i_rst_n,
        !r_oval || r_state == des_pkg::ST_OUT_HOLD, "result shown outside hold")
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, out_xfer && r_olast,
        r_count == '0 && !r_ovf, "set state not cleared after last result")
endmodule

// ===== hw/rtl/des_ram.sv =====
// generic single-port ram with registered read
module des_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/tb_top.sv =====
// testbench for the descending exchange sorter: directed table, then random sets
module tb_top;

    localparam int unsigned N_MAX = 32;
    localparam int unsigned TAGW  = 16;

    // one stored or emitted entry
    typedef struct packed {
        logic [63:0]     w3;
        logic [63:0]     w2;
        logic [63:0]     w1;
        logic [63:0]     w0;
        logic            scored;
        logic [TAGW-1:0] tag;
    } t_entry;

    typedef struct packed {
        t_entry ent;
        logic   lst;
        logic   ovf;
    } t_sorted;

    // directed row: entry and last flag
    typedef struct packed {
        t_entry ent;
        logic   lst;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [63:0]         i_key_word3, i_key_word2, i_key_word1, i_key_word0;
    logic                i_has_score;
    logic [TAGW-1:0]     i_tag;
    logic                i_last;
    logic                o_valid;
    logic                i_stall;
    logic [63:0]         o_out_key_word3, o_out_key_word2, o_out_key_word1, o_out_key_word0;
    logic                o_out_has_score;
    logic [TAGW-1:0]     o_out_tag;
    logic                o_out_last;
    logic                o_overflowed;

    descending_exchange_sorter_core #(
        .MAX_ENTRIES(N_MAX),
        .TAG_BITS   (TAGW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_key_word3    (i_key_word3),
        .i_key_word2    (i_key_word2),
        .i_key_word1    (i_key_word1),
        .i_key_word0    (i_key_word0),
        .i_has_score    (i_has_score),
        .i_tag          (i_tag),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_key_word3(o_out_key_word3),
        .o_out_key_word2(o_out_key_word2),
        .o_out_key_word1(o_out_key_word1),
        .o_out_key_word0(o_out_key_word0),
        .o_out_has_score(o_out_has_score),
        .o_out_tag      (o_out_tag),
        .o_out_last     (o_out_last),
        .o_overflowed   (o_overflowed)
    );

    // predictor state: the set being loaded
    t_entry  load_set[N_MAX];
    int      load_count;
    logic    load_dropped;
    t_sorted sorted_queue[$];

    int  mismatches;
    bit  test_failed;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [255:0] full_key(t_entry e);
        return {e.w3, e.w2, e.w1, e.w0};
    endfunction

    // absorb one accepted transfer; on last, sort descending and queue the set
    function automatic void sorter_accept(t_entry e, logic lst);
        t_entry tmp;
        t_sorted r;
        if (load_count < N_MAX) begin
            load_set[load_count] = e;
            load_count++;
        end else begin
            load_dropped = 1'b1;
        end
        if (!lst) return;
        // exact exchange sort: unscored entries never move
        for (int i = 0; i + 1 < load_count; i++) begin
            for (int j = i + 1; j < load_count; j++) begin
                if (load_set[i].scored && load_set[j].scored &&
                    full_key(load_set[i]) < full_key(load_set[j])) begin
                    tmp = load_set[i];
                    load_set[i] = load_set[j];
                    load_set[j] = tmp;
                end
            end
        end
        for (int i = 0; i < load_count; i++) begin
            r.ent = load_set[i];
            r.lst = (i == load_count - 1);
            r.ovf = load_dropped;
            sorted_queue.push_back(r);
        end
        load_count   = 0;
        load_dropped = 1'b0;
    endfunction

    function automatic void note_mismatch(string what, t_sorted exp_r, t_sorted act_r);
        mismatches++;
        test_failed = 1'b1;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", what, exp_r, act_r);
    endfunction

    // output side: random stall, check each result transfer
    initial begin
        t_sorted got, want;
        int hold;
        hold = 0;
        i_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got.ent = {o_out_key_word3, o_out_key_word2, o_out_key_word1,
                           o_out_key_word0, o_out_has_score, o_out_tag};
                got.lst = o_out_last;
                got.ovf = o_overflowed;
                if (sorted_queue.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = sorted_queue.pop_front();
                    if (got.ent.w3 !== want.ent.w3 || got.ent.w2 !== want.ent.w2 ||
                        got.ent.w1 !== want.ent.w1 || got.ent.w0 !== want.ent.w0)
                        note_mismatch("key", want, got);
                    else if (got.ent.scored !== want.ent.scored)
                        note_mismatch("has_score", want, got);
                    else if (got.ent.tag !== want.ent.tag)
                        note_mismatch("tag", want, got);
                    else if (got.lst !== want.lst)
                        note_mismatch("last", want, got);
                    else if (got.ovf !== want.ovf)
                        note_mismatch("overflowed", want, got);
                end
            end
            // mostly no stall, some short stalls, a few long ones
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        if ($urandom_range(0, 7) == 0) hold = $urandom_range(10, 40);
                        i_stall <= 1'b1;
                    end
                    1:       i_stall <= 1'b1;
                    2:       i_stall <= ($urandom_range(0, 19) == 0);
                    default: i_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic logic [63:0] rand_word(int mode);
        case (mode)
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // keys often share upper words so the lower-word compare gets exercised
    function automatic t_entry rand_entry();
        t_entry e;
        int m;
        m = $urandom_range(0, 5);
        e.w3 = rand_word(m < 3 ? 2 : 3);
        e.w2 = rand_word(m < 2 ? 2 : $urandom_range(0, 3));
        e.w1 = rand_word($urandom_range(0, 3));
        e.w0 = rand_word($urandom_range(0, 3));
        e.scored = ($urandom_range(0, 4) != 0);
        e.tag = TAGW'($urandom);
        return e;
    endfunction

    // one input transfer, with a random gap first; waits for acceptance
    task automatic send_entry(t_entry e, logic lst);
        int gap;
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key_word3 <= e.w3;
        i_key_word2 <= e.w2;
        i_key_word1 <= e.w1;
        i_key_word0 <= e.w0;
        i_has_score <= e.scored;
        i_tag       <= e.tag;
        i_last      <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sorter_accept(e, lst);
    endtask

    // drop valid before the sender waits on anything
    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    t_row directed[$];

    function automatic t_entry mk(logic [63:0] w3, logic [63:0] w0, logic s,
                                  logic [TAGW-1:0] t);
        t_entry e;
        e.w3 = w3; e.w2 = '0; e.w1 = '0; e.w0 = w0; e.scored = s; e.tag = t;
        return e;
    endfunction

    initial begin
        t_sorted first_exp;
        int n, sets;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_key_word3 = '0;
        i_key_word2 = '0;
        i_key_word1 = '0;
        i_key_word0 = '0;
        i_has_score = 1'b0;
        i_tag       = '0;
        i_last      = 1'b0;
        load_count  = 0;
        load_dropped = 1'b0;
        mismatches  = 0;
        test_failed = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-entry set of all ones: comes straight back, typed-in result
        first_exp.ent = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         1'b1, 16'hFFFF};
        first_exp.lst = 1'b1;
        first_exp.ovf = 1'b0;
        send_entry(first_exp.ent, 1'b1);
        if (sorted_queue[0] !== first_exp) begin
            test_failed = 1'b1;
            $display("predictor disagrees with typed-in single entry result");
        end

        // extremes, ties, a fixed unscored entry in the middle, low-word compare
        directed.push_back('{mk('0, '0, 1'b1, 16'h0000), 1'b0});
        directed.push_back('{mk('1, '1, 1'b1, 16'hFFFF), 1'b0});
        directed.push_back('{mk('1, '0, 1'b0, 16'h00AA), 1'b0});
        directed.push_back('{mk('0, 64'd1, 1'b1, 16'h5555), 1'b0});
        directed.push_back('{mk('0, 64'd1, 1'b1, 16'hAAAA), 1'b0});
        directed.push_back('{mk(64'h8000_0000_0000_0000, '0, 1'b1, 16'h1234), 1'b1});
        directed.push_back('{mk('0, '0, 1'b0, 16'h0001), 1'b0});
        directed.push_back('{mk('1, '1, 1'b0, 16'h0002), 1'b1});
        foreach (directed[k]) send_entry(directed[k].ent, directed[k].lst);

        // full store plus two dropped entries, last one dropped too
        for (int k = 0; k < N_MAX + 2; k++) send_entry(rand_entry(), k == N_MAX + 1);
        // exactly full, no overflow
        for (int k = 0; k < N_MAX; k++) send_entry(rand_entry(), k == N_MAX - 1);

        // random sets: mostly small, a few near or past capacity
        sets = 0;
        while (sets < 28) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(N_MAX - 1, N_MAX + 3)
                                            : $urandom_range(1, 6);
            for (int k = 0; k < n; k++) send_entry(rand_entry(), k == n - 1);
            sets++;
            // hold off until the whole sorted set has drained
            if (sets % 10 == 0) begin
                idle_input();
                while (sorted_queue.size() != 0) @(posedge i_clk);
            end
        end
        idle_input();
        while (sorted_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!test_failed && load_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // slowest run: every set full with a swap on each compare, plus stalls, far below this bound
    initial begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
